// ===== rtl/core/rrs_pkg.sv =====
// Shared widths, constants and controller/datapath interface types of the round-robin scheduler
`timescale 1ns / 1ps
`default_nettype none

package rrs_pkg;

	// field widths
	localparam int unsigned ARR_W   = 16;
	localparam int unsigned BUR_W   = 16;
	localparam int unsigned QTM_W   = 16;
	localparam int unsigned TIME_W  = 22;
	localparam int unsigned PIDX_W  = 6;

	// default batch capacity and quantum after reset
	localparam int unsigned          MAX_PROCESSES_DEF = 16;
	localparam logic [QTM_W-1:0]     QUANTUM_RESET     = 16'd2;

	// controller states
	typedef enum logic [10:0] {
		ST_IDLE      = 11'b000_0000_0001,
		ST_CHECK     = 11'b000_0000_0010,
		ST_SCAN_REQ  = 11'b000_0000_0100,
		ST_SCAN_EVAL = 11'b000_0000_1000,
		ST_DECIDE    = 11'b000_0001_0000,
		ST_POP       = 11'b000_0010_0000,
		ST_RUN_RD    = 11'b000_0100_0000,
		ST_RUN_EXEC  = 11'b000_1000_0000,
		ST_OUT_RD    = 11'b001_0000_0000,
		ST_OUT_CALC  = 11'b010_0000_0000,
		ST_OUT_SEND  = 11'b100_0000_0000
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;       // store one process request
		logic restart;    // index back to zero, clear minimum search
		logic scan_eval;  // admission check of the indexed process
		logic idx_next;   // step the shared index
		logic time_jump;  // advance time to the earliest pending arrival
		logic pop;        // take the head of the ready queue
		logic run_exec;   // run one slice of the popped process
		logic out_calc;   // compute turnaround of the indexed process
		logic out_load;   // fill the result register
		logic clear;      // drop the batch
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic all_done;
		logic idx_end;
		logic fifo_empty;
		logic min_found;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/core/round_robin_schedule_sim.sv =====
// Top level of the round-robin schedule simulator: sequencer plus datapath
//
// Usage: processes are loaded one request per cycle on the input channel
// (arrival_time, burst_time, last_process) in index order; up to
// MAX_PROCESSES are stored, further requests are dropped. The request with
// last_process set starts the schedule, during which in_ready is low.
// The user must write the quantum register through cfg_we/cfg_wdata only idle;
// the block itself does not enforce this. A quantum of zero acts as one.
// Schedule steps: each decision point runs a check, an admission scan over
// the N loaded processes (a read and an evaluation per process) and the
// decision, then a slice (queue read, remaining read, update). An idle-time
// jump costs one decision point without a slice.
// Results follow in index order, each from a store read, a turnaround
// step and the waiting time step; the last carries last_result. A stalled
// out_ready holds the result register and the sequencer until it is taken.
// After the last result is loaded, the block returns to idle and takes new
// requests while that result still waits. Reset clears all control state
// and sets the quantum to 2; the stores need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_schedule_sim
	import rrs_pkg::*;
#(
	parameter int unsigned MAX_PROCESSES = MAX_PROCESSES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [QTM_W-1:0]  cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [ARR_W-1:0]  arrival_time,
	input  wire logic [BUR_W-1:0]  burst_time,
	input  wire logic              last_process,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [PIDX_W-1:0]      process_index,
	output logic [TIME_W-1:0]      completion_time,
	output logic [TIME_W-1:0]      turnaround_time,
	output logic [TIME_W-1:0]      waiting_time,
	output logic                   last_result
);

	cmd_t    cmd;
	status_t status;

	// sequencer
	rrs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.last_process (last_process),
		.in_ready     (in_ready),
		.status       (status),
		.cmd          (cmd)
	);

	// stores, queue and result register
	rrs_datapath #(
		.MAX_PROCESSES (MAX_PROCESSES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.arrival_time    (arrival_time),
		.burst_time      (burst_time),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.process_index   (process_index),
		.completion_time (completion_time),
		.turnaround_time (turnaround_time),
		.waiting_time    (waiting_time),
		.last_result     (last_result)
	);

	// the result register is only refilled once it is free
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free)
		else $error("result register refilled while occupied");

	// a pop never hits an empty ready queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !status.fifo_empty)
		else $error("pop from empty ready queue");

	// store-touching commands are mutually exclusive
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.scan_eval, cmd.pop, cmd.run_exec, cmd.out_load}))
		else $error("conflicting datapath commands");

	// intake is closed while a result is being loaded
	a_no_intake_on_output: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !in_ready)
		else $error("intake open during result output");

endmodule

`default_nettype wire

// ===== rtl/core/rrs_ctrl.sv =====
// Sequencer of the round-robin scheduler: load, admission scan, slice runs and result output
`timescale 1ns / 1ps
`default_nettype none

module rrs_ctrl
	import rrs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    last_process,
	output logic         in_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last_process) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				cmd.restart = 1'b1;
				state_d = status.all_done ? ST_OUT_RD : ST_SCAN_REQ;
			end
			ST_SCAN_REQ: begin
				state_d = ST_SCAN_EVAL;
			end
			ST_SCAN_EVAL: begin
				cmd.scan_eval = 1'b1;
				if (status.idx_end) begin
					state_d = ST_DECIDE;
				end else begin
					cmd.idx_next = 1'b1;
					state_d = ST_SCAN_REQ;
				end
			end
			ST_DECIDE: begin
				if (!status.fifo_empty) begin
					state_d = ST_POP;
				end else if (status.min_found) begin
					cmd.time_jump = 1'b1;
					state_d = ST_CHECK;
				end else begin
					// nothing left to admit: report what is there
					cmd.restart = 1'b1;
					state_d = ST_OUT_RD;
				end
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				state_d = ST_RUN_RD;
			end
			ST_RUN_RD: begin
				state_d = ST_RUN_EXEC;
			end
			ST_RUN_EXEC: begin
				cmd.run_exec = 1'b1;
				state_d = ST_CHECK;
			end
			ST_OUT_RD: begin
				state_d = ST_OUT_CALC;
			end
			ST_OUT_CALC: begin
				cmd.out_calc = 1'b1;
				state_d = ST_OUT_SEND;
			end
			ST_OUT_SEND: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					if (status.idx_end) begin
						cmd.clear = 1'b1;
						state_d = ST_IDLE;
					end else begin
						cmd.idx_next = 1'b1;
						state_d = ST_OUT_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/rrs_datapath.sv =====
// Process stores, ready queue, time keeping and result register of the round-robin scheduler
`timescale 1ns / 1ps
`default_nettype none

module rrs_datapath
	import rrs_pkg::*;
#(
	parameter int unsigned MAX_PROCESSES = MAX_PROCESSES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output status_t                status,
	input  wire logic [ARR_W-1:0]  arrival_time,
	input  wire logic [BUR_W-1:0]  burst_time,
	input  wire logic              cfg_we,
	input  wire logic [QTM_W-1:0]  cfg_wdata,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic [PIDX_W-1:0]      process_index,
	output logic [TIME_W-1:0]      completion_time,
	output logic [TIME_W-1:0]      turnaround_time,
	output logic [TIME_W-1:0]      waiting_time,
	output logic                   last_result
);

	localparam int unsigned IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_PROCESSES + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_PROCESSES - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PROCESSES);

	// stores
	logic [ARR_W-1:0]  arr_mem  [MAX_PROCESSES];
	logic [BUR_W-1:0]  bur_mem  [MAX_PROCESSES];
	logic [BUR_W-1:0]  rem_mem  [MAX_PROCESSES];
	logic [TIME_W-1:0] cmp_mem  [MAX_PROCESSES];
	logic [IDX_W-1:0]  fifo_mem [MAX_PROCESSES];

	logic [ARR_W-1:0]  arr_rd_q;
	logic [BUR_W-1:0]  bur_rd_q;
	logic [BUR_W-1:0]  rem_rd_q;
	logic [TIME_W-1:0] cmp_rd_q;
	logic [IDX_W-1:0]  fifo_rd_q;

	// control registers
	logic [QTM_W-1:0]         quantum_q;
	logic [CNT_W-1:0]         loaded_q;
	logic [CNT_W-1:0]         finished_q;
	logic [TIME_W-1:0]        time_q;
	logic [IDX_W-1:0]         idx_q;
	logic [IDX_W-1:0]         head_q;
	logic [IDX_W-1:0]         tail_q;
	logic [CNT_W-1:0]         fifo_cnt_q;
	logic [MAX_PROCESSES-1:0] adm_q;
	logic                     min_found_q;
	logic                     out_valid_q;

	// payload registers
	logic [ARR_W-1:0]  min_q;
	logic [IDX_W-1:0]  p_q;
	logic [TIME_W-1:0] tat_q;
	logic [PIDX_W-1:0] pidx_q;
	logic [TIME_W-1:0] ct_q;
	logic [TIME_W-1:0] tt_q;
	logic [TIME_W-1:0] wt_q;
	logic              last_q;

	logic             store_en;
	logic [IDX_W-1:0] load_addr;
	logic             arrived;
	logic             scan_push;
	logic [QTM_W-1:0] q_eff;
	logic [BUR_W-1:0] slice;
	logic [BUR_W-1:0] rem_new;
	logic [TIME_W:0]  time_sum;
	logic [TIME_W-1:0] time_new;
	logic             run_done;
	logic             push_en;
	logic [IDX_W-1:0] push_idx;
	logic [TIME_W-1:0] wt_calc;

	assign store_en  = cmd.load && (loaded_q != CNT_FULL);
	assign load_addr = loaded_q[IDX_W-1:0];

	// admission check of the indexed process
	assign arrived   = (TIME_W'(arr_rd_q) <= time_q);
	assign scan_push = cmd.scan_eval && !adm_q[idx_q] && arrived;

	// one slice: min(remaining, quantum), time saturates at its top
	assign q_eff    = (quantum_q == '0) ? QTM_W'(1) : quantum_q;
	assign slice    = (rem_rd_q < q_eff) ? rem_rd_q : q_eff;
	assign rem_new  = rem_rd_q - slice;
	assign time_sum = {1'b0, time_q} + (TIME_W + 1)'(slice);
	assign time_new = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
	assign run_done = (rem_new == '0);

	assign push_en  = scan_push || (cmd.run_exec && !run_done);
	assign push_idx = cmd.run_exec ? p_q : idx_q;

	assign wt_calc = (tat_q >= TIME_W'(bur_rd_q)) ? tat_q - TIME_W'(bur_rd_q) : '0;

	// arrival and burst stores
	always_ff @(posedge clk) begin
		if (store_en) begin
			arr_mem[load_addr] <= arrival_time;
			bur_mem[load_addr] <= burst_time;
		end
		arr_rd_q <= arr_mem[idx_q];
		bur_rd_q <= bur_mem[idx_q];
	end

	// remaining service store
	always_ff @(posedge clk) begin
		if (store_en) begin
			rem_mem[load_addr] <= burst_time;
		end else if (cmd.run_exec) begin
			rem_mem[p_q] <= rem_new;
		end
		rem_rd_q <= rem_mem[p_q];
	end

	// completion store
	always_ff @(posedge clk) begin
		if (cmd.run_exec && run_done) begin
			cmp_mem[p_q] <= time_new;
		end
		cmp_rd_q <= cmp_mem[idx_q];
	end

	// ready queue storage
	always_ff @(posedge clk) begin
		if (push_en) begin
			fifo_mem[tail_q] <= push_idx;
		end
		fifo_rd_q <= fifo_mem[head_q];
	end

	// batch control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q   <= QUANTUM_RESET;
			loaded_q    <= '0;
			finished_q  <= '0;
			time_q      <= '0;
			idx_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			fifo_cnt_q  <= '0;
			adm_q       <= '0;
			min_found_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				quantum_q <= cfg_wdata;
			end
			if (store_en) begin
				loaded_q <= loaded_q + CNT_W'(1);
			end
			if (cmd.restart) begin
				idx_q       <= '0;
				min_found_q <= 1'b0;
			end else if (cmd.idx_next) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			// track the earliest arrival still outside the queue
			if (cmd.scan_eval && !adm_q[idx_q] && !arrived) begin
				if (!min_found_q || arr_rd_q < min_q) begin
					min_found_q <= 1'b1;
				end
			end
			if (scan_push) begin
				adm_q[idx_q] <= 1'b1;
			end
			if (cmd.time_jump) begin
				time_q <= TIME_W'(min_q);
			end
			if (cmd.run_exec) begin
				time_q <= time_new;
				if (run_done) begin
					finished_q <= finished_q + CNT_W'(1);
				end
			end
			// queue pointers
			if (cmd.pop) begin
				head_q <= (head_q == IDX_LAST) ? '0 : head_q + IDX_W'(1);
			end
			if (push_en) begin
				tail_q <= (tail_q == IDX_LAST) ? '0 : tail_q + IDX_W'(1);
			end
			if (cmd.pop && !push_en) begin
				fifo_cnt_q <= fifo_cnt_q - CNT_W'(1);
			end else if (push_en && !cmd.pop) begin
				fifo_cnt_q <= fifo_cnt_q + CNT_W'(1);
			end
			if (cmd.clear) begin
				loaded_q   <= '0;
				finished_q <= '0;
				time_q     <= '0;
				head_q     <= '0;
				tail_q     <= '0;
				fifo_cnt_q <= '0;
				adm_q      <= '0;
			end
		end
	end

	// minimum value, popped process and turnaround
	always_ff @(posedge clk) begin
		if (cmd.scan_eval && !adm_q[idx_q] && !arrived && (!min_found_q || arr_rd_q < min_q)) begin
			min_q <= arr_rd_q;
		end
		if (cmd.pop) begin
			p_q <= fifo_rd_q;
		end
		if (cmd.out_calc) begin
			tat_q <= (cmp_rd_q >= TIME_W'(arr_rd_q)) ? cmp_rd_q - TIME_W'(arr_rd_q) : '0;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pidx_q <= PIDX_W'(idx_q);
			ct_q   <= cmp_rd_q;
			tt_q   <= tat_q;
			wt_q   <= wt_calc;
			last_q <= status.idx_end;
		end
	end

	assign status.all_done   = (finished_q == loaded_q);
	assign status.idx_end    = (CNT_W'(idx_q) == loaded_q - CNT_W'(1));
	assign status.fifo_empty = (fifo_cnt_q == '0);
	assign status.min_found  = min_found_q;
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign process_index   = pidx_q;
	assign completion_time = ct_q;
	assign turnaround_time = tt_q;
	assign waiting_time    = wt_q;
	assign last_result     = last_q;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the round-robin schedule simulator, with a built-in schedule predictor
`timescale 1ns / 1ps

module testbench;
	import rrs_pkg::*;

	localparam int          MAXP         = MAX_PROCESSES_DEF;
	localparam int unsigned TIME_MAX     = 4194303;
	localparam int          RANDOM_ITEMS = 195;
	localparam int          CYCLE_LIMIT  = 2000000;
	localparam int          SHOW_LIMIT   = 10;

	// one reported process
	typedef struct packed {
		logic [PIDX_W-1:0] proc;
		logic [TIME_W-1:0] completion;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
		logic              last;
	} sched_result_t;

	// one row of the directed table
	typedef struct packed {
		logic              q_write;
		logic [QTM_W-1:0]  q_value;
		logic [ARR_W-1:0]  arrival;
		logic [BUR_W-1:0]  burst;
		logic              last;
		logic              typed;
		logic [TIME_W-1:0] typed_ct;
		logic [TIME_W-1:0] typed_tat;
		logic [TIME_W-1:0] typed_wt;
	} stim_row_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              cfg_we       = 1'b0;
	logic [QTM_W-1:0]  cfg_wdata    = '0;
	logic              in_valid     = 1'b0;
	logic [ARR_W-1:0]  arrival_time = '0;
	logic [BUR_W-1:0]  burst_time   = '0;
	logic              last_process = 1'b0;
	logic              out_ready    = 1'b0;
	logic              in_ready;
	logic              out_valid;
	logic [PIDX_W-1:0] process_index;
	logic [TIME_W-1:0] completion_time;
	logic [TIME_W-1:0] turnaround_time;
	logic [TIME_W-1:0] waiting_time;
	logic              last_result;

	round_robin_schedule_sim u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.arrival_time    (arrival_time),
		.burst_time      (burst_time),
		.last_process    (last_process),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.process_index   (process_index),
		.completion_time (completion_time),
		.turnaround_time (turnaround_time),
		.waiting_time    (waiting_time),
		.last_result     (last_result)
	);

	// predictor state: loaded batch and quantum
	logic [ARR_W-1:0] arr_mem [MAXP];
	logic [BUR_W-1:0] bur_mem [MAXP];
	int unsigned      rem_mem [MAXP];
	int unsigned      done_at [MAXP];
	bit               admitted [MAXP];
	int               loaded_n      = 0;
	logic [QTM_W-1:0] quantum_model = QUANTUM_RESET;

	sched_result_t sched_expect_q [$];
	sched_result_t batch_results [$];
	stim_row_t     directed_rows [$];

	int            mismatch_count = 0;
	int            cycle_count    = 0;
	int            burst_left     = 0;
	sched_result_t seen_result;
	sched_result_t want_result;

	// receiver stall pattern
	int       stall_left = 0;
	int       stall_mode = 0;
	logic [7:0] stall_mask = 8'hff;
	logic [2:0] stall_phase = '0;

	initial begin
		forever #6 clk = ~clk;
	end

	// store one request and, on the last mark, run the round-robin schedule of the batch
	task automatic predict_request(input logic [ARR_W-1:0] a, input logic [BUR_W-1:0] b,
			input logic l);
		int unsigned q;
		int unsigned t;
		int unsigned slice;
		int unsigned nxt;
		int unsigned ct;
		int unsigned tat;
		int unsigned wt;
		int          done;
		int          p;
		int          rr_queue [$];
		sched_result_t r;
		if (loaded_n < MAXP) begin
			arr_mem[loaded_n]  = a;
			bur_mem[loaded_n]  = b;
			rem_mem[loaded_n]  = b;
			admitted[loaded_n] = 1'b0;
			loaded_n++;
		end
		batch_results.delete();
		if (!l)
			return;
		q    = (quantum_model == 0) ? 1 : quantum_model;
		t    = 0;
		done = 0;
		while (done < loaded_n) begin
			// admission in index order
			for (int i = 0; i < loaded_n; i++) begin
				if (!admitted[i] && arr_mem[i] <= t) begin
					admitted[i] = 1'b1;
					rr_queue = {rr_queue, i};
				end
			end
			// idle: jump to the earliest pending arrival
			if (rr_queue.size() == 0) begin
				nxt = TIME_MAX + 1;
				for (int i = 0; i < loaded_n; i++)
					if (!admitted[i] && arr_mem[i] < nxt)
						nxt = arr_mem[i];
				if (nxt > TIME_MAX)
					break;
				t = nxt;
				continue;
			end
			// one slice of the head process
			p     = rr_queue.pop_front();
			slice = (rem_mem[p] < q) ? rem_mem[p] : q;
			t     = t + slice;
			if (t > TIME_MAX)
				t = TIME_MAX;
			rem_mem[p] = rem_mem[p] - slice;
			if (rem_mem[p] == 0) begin
				done_at[p] = t;
				done++;
			end else begin
				rr_queue = {rr_queue, p};
			end
		end
		// per-process report
		for (int i = 0; i < loaded_n; i++) begin
			ct  = done_at[i];
			tat = (ct >= arr_mem[i]) ? ct - arr_mem[i] : 0;
			wt  = (tat >= bur_mem[i]) ? tat - bur_mem[i] : 0;
			r.proc       = PIDX_W'(i);
			r.completion = TIME_W'(ct);
			r.turnaround = TIME_W'(tat);
			r.waiting    = TIME_W'(wt);
			r.last       = (i == loaded_n - 1);
			batch_results = {batch_results, r};
		end
		loaded_n = 0;
	endtask

	// offer one request in sender bursts, wait for acceptance, then predict
	task automatic drive_request(input logic [ARR_W-1:0] a, input logic [BUR_W-1:0] b,
			input logic l, input logic typed, input sched_result_t typed_res);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 7) == 0)
				burst_left = 48;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
		burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		arrival_time <= a;
		burst_time   <= b;
		last_process <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_request(a, b, l);
		if (l) begin
			if (typed)
				sched_expect_q = {sched_expect_q, typed_res};
			else
				sched_expect_q = {sched_expect_q, batch_results};
		end
	endtask

	// quantum write once the block has drained
	task automatic set_quantum(input logic [QTM_W-1:0] q);
		in_valid <= 1'b0;
		while (sched_expect_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= q;
		@(posedge clk);
		cfg_we        <= 1'b0;
		quantum_model = q;
	endtask

	function automatic void add_row(input logic qw, input int qv, input int a, input int b,
			input logic l, input logic ty, input int ct, input int tat, input int wt);
		stim_row_t row;
		row.q_write   = qw;
		row.q_value   = QTM_W'(qv);
		row.arrival   = ARR_W'(a);
		row.burst     = BUR_W'(b);
		row.last      = l;
		row.typed     = ty;
		row.typed_ct  = TIME_W'(ct);
		row.typed_tat = TIME_W'(tat);
		row.typed_wt  = TIME_W'(wt);
		directed_rows = {directed_rows, row};
	endfunction

	task automatic flag_result(input string why, input sched_result_t want,
			input sched_result_t got);
		mismatch_count++;
		if (mismatch_count <= SHOW_LIMIT)
			$display({"%s: expected idx %0d ct %0d tat %0d wt %0d last %0d,",
				" got idx %0d ct %0d tat %0d wt %0d last %0d"},
				why, want.proc, want.completion, want.turnaround, want.waiting, want.last,
				got.proc, got.completion, got.turnaround, got.waiting, got.last);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_result = {process_index, completion_time, turnaround_time, waiting_time,
				last_result};
			if (sched_expect_q.size() == 0) begin
				flag_result("unexpected result", '0, seen_result);
			end else begin
				want_result = sched_expect_q.pop_front();
				if (seen_result !== want_result)
					flag_result("result mismatch", want_result, seen_result);
			end
		end
	end

	// receiver stalls: always ready, coin flip, or a rotating mask
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(16, 64);
			stall_mask <= 8'($urandom_range(1, 255));
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= 1'($urandom_range(0, 1));
			end
			default: begin
				out_ready <= stall_mask[stall_phase];
			end
		endcase
		stall_phase <= stall_phase + 3'd1;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		stim_row_t     row;
		sched_result_t typed_res;
		sched_result_t no_res;
		int            random_sent;
		int            batch_size;
		int            pick;
		int            arr_style;
		int            base;
		int            a;
		int            b;
		logic          long_mode;
		logic          need_q;
		logic [QTM_W-1:0] next_q;

		no_res      = '0;
		random_sent = 0;

		// directed table
		// single request after reset with the reset quantum
		add_row(1'b0, 0, 0, 5, 1'b1, 1'b1, 5, 5, 0);
		// largest arrival and burst under the largest quantum
		add_row(1'b1, 65535, 65535, 65535, 1'b1, 1'b1, 131070, 65535, 0);
		// zero burst completes on arrival
		add_row(1'b0, 0, 7, 0, 1'b1, 1'b1, 7, 0, 0);
		// zero quantum acts as one
		add_row(1'b1, 0, 0, 3, 1'b0, 1'b0, 0, 0, 0);
		add_row(1'b0, 0, 1, 2, 1'b0, 1'b0, 0, 0, 0);
		add_row(1'b0, 0, 2, 1, 1'b1, 1'b0, 0, 0, 0);
		// unit quantum with idle jumps
		add_row(1'b1, 1, 1, 2, 1'b0, 1'b0, 0, 0, 0);
		add_row(1'b0, 0, 9, 3, 1'b1, 1'b0, 0, 0, 0);
		// overflow: seventeenth request is dropped but still starts the schedule
		for (int i = 0; i < 17; i++)
			add_row(i == 0, 3, i * 2, (i % 5) + 1, i == 16, 1'b0, 0, 0, 0);

		// reset
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.q_write)
				set_quantum(row.q_value);
			typed_res.proc       = '0;
			typed_res.completion = row.typed_ct;
			typed_res.turnaround = row.typed_tat;
			typed_res.waiting    = row.typed_wt;
			typed_res.last       = 1'b1;
			drive_request(row.arrival, row.burst, row.last, row.typed, typed_res);
		end

		// random batches: short bursts under small quanta, long bursts under large ones
		while (random_sent < RANDOM_ITEMS) begin
			long_mode = ($urandom_range(0, 9) >= 7);
			pick      = $urandom_range(0, 9);
			if (pick < 7)
				batch_size = $urandom_range(1, 6);
			else if (pick < 9)
				batch_size = $urandom_range(7, 16);
			else
				batch_size = $urandom_range(17, 20);
			if (long_mode) begin
				need_q = (quantum_model < 16384);
				next_q = ($urandom_range(0, 3) == 0) ? 16'hffff :
					QTM_W'($urandom_range(16384, 65535));
			end else begin
				need_q = (quantum_model > 4);
				next_q = QTM_W'($urandom_range(0, 4));
			end
			if (need_q || $urandom_range(0, 1) == 1)
				set_quantum(next_q);
			arr_style = $urandom_range(0, 2);
			base      = 0;
			for (int k = 0; k < batch_size; k++) begin
				case (arr_style)
					0: begin
						a = $urandom_range(0, 30);
					end
					1: begin
						a = $urandom_range(0, 65535);
					end
					default: begin
						base = base + $urandom_range(0, 20);
						a    = (base > 65535) ? 65535 : base;
					end
				endcase
				if (long_mode)
					b = $urandom_range(0, 65535);
				else
					b = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
				drive_request(ARR_W'(a), BUR_W'(b), k == batch_size - 1, 1'b0, no_res);
				random_sent++;
			end
		end

		// drain
		in_valid <= 1'b0;
		while (sched_expect_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatch_count == 0 && sched_expect_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
